// File: sv/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg: shared types and helpers for the Life row stepper
// Row and register widths, the result beat layout and the column mask
// helpers used by the top level and the lane array.
// ----------------------------------------------------------------------------
package lrs_pkg;

  // Widest grid the block supports, in columns.
  localparam int MAX_WIDTH = 64;
  // Width of the grid width register.
  localparam int CFG_W     = 7;
  // Depth of the result queue and its pointer width.
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  // One result beat.
  typedef struct packed {
    logic [MAX_WIDTH-1:0] next_row;
    logic                 frame_end;
    logic                 grid_changed;
  } lrs_res_t;

  // Results that one accepted row pushes into the queue, first one in slot 0.
  typedef struct packed {
    logic [1:0] count;
    lrs_res_t   slot0;
    lrs_res_t   slot1;
  } lrs_push_t;

  // Width in force, clamped to the widest supported grid.
  function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] w);
    logic [CFG_W-1:0] r;
    r = (w > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : w;
    return r;
  endfunction

  // Ones over the columns in use.
  function automatic logic [MAX_WIDTH-1:0] width_mask(input logic [CFG_W-1:0] w);
    logic [MAX_WIDTH-1:0] m;
    if (w >= CFG_W'(MAX_WIDTH)) begin
      m = '1;
    end else begin
      m = (MAX_WIDTH'(1) << w) - MAX_WIDTH'(1);
    end
    return m;
  endfunction

  // Ones over the columns in use, without the two border columns.
  function automatic logic [MAX_WIDTH-1:0] interior_mask(input logic [CFG_W-1:0] w);
    logic [MAX_WIDTH-1:0] m;
    m = width_mask(w);
    if (w == '0) begin
      m = '0;
    end else begin
      m = m & ~MAX_WIDTH'(1);
      m = m & ~(MAX_WIDTH'(1) << (w - CFG_W'(1)));
    end
    return m;
  endfunction

endpackage

// File: sv/lrs_lane.sv
// ----------------------------------------------------------------------------
// lrs_lane: next state of one cell
// Counts the eight neighbors of one cell and applies birth on three and
// survival on two or three.
// ----------------------------------------------------------------------------
module lrs_lane (
  input  logic [2:0] up,
  input  logic [2:0] mid,
  input  logic [2:0] down,
  input  logic       en,
  output logic       alive
);

  logic [3:0] nbr;

  // Neighbor count, the cell itself left out.
  assign nbr = 4'(up[0]) + 4'(up[1]) + 4'(up[2])
             + 4'(mid[0]) + 4'(mid[2])
             + 4'(down[0]) + 4'(down[1]) + 4'(down[2]);

  // Birth and survival rule, only for interior columns.
  assign alive = en && ((nbr == 4'd3) || ((nbr == 4'd2) && mid[1]));

endmodule

// File: sv/lrs_core.sv
// ----------------------------------------------------------------------------
// lrs_core: lane array and change merge
// One lane per interior column computes the next row side by side; the
// merge stage folds the per-column differences into one change flag.
// ----------------------------------------------------------------------------
module lrs_core (
  input  logic [lrs_pkg::MAX_WIDTH-1:0] up_row,
  input  logic [lrs_pkg::MAX_WIDTH-1:0] mid_row,
  input  logic [lrs_pkg::MAX_WIDTH-1:0] down_row,
  input  logic [lrs_pkg::MAX_WIDTH-1:0] inner,
  output logic [lrs_pkg::MAX_WIDTH-1:0] next_row,
  output logic                          changed
);

  localparam int W = lrs_pkg::MAX_WIDTH;

  // Border columns of the next generation are always dead.
  assign next_row[0]   = 1'b0;
  assign next_row[W-1] = 1'b0;

  // One lane per column that has both neighbors.
  for (genvar j = 1; j < W - 1; j++) begin : g_lane
    lrs_lane u_lane (
      .up    (up_row[j+1:j-1]),
      .mid   (mid_row[j+1:j-1]),
      .down  (down_row[j+1:j-1]),
      .en    (inner[j]),
      .alive (next_row[j])
    );
  end

  // Merge: any column whose next state differs from its present state.
  assign changed = |(next_row ^ mid_row);

endmodule

// File: sv/lrs_outq.sv
// ----------------------------------------------------------------------------
// lrs_outq: result queue
// Small queue that takes up to two result beats a cycle and hands out one,
// so a row that ends a frame does not hold up the input side.
// ----------------------------------------------------------------------------
module lrs_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  lrs_pkg::lrs_push_t  push,
  input  logic                pop,
  output logic                not_empty,
  output logic                almost_full,
  output lrs_pkg::lrs_res_t   head
);

  localparam int QDEPTH = lrs_pkg::QDEPTH;
  localparam int QPTR_W = lrs_pkg::QPTR_W;
  localparam int QCNT_W = lrs_pkg::QCNT_W;

  lrs_pkg::lrs_res_t    entries_r [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]    count_r, count_nxt;
  logic [QPTR_W-1:0]    wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.count);
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry writes, first result at the write pointer, second just after it.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries_r[wr_ptr_r] <= push.slot0;
    end
    if (push.count == 2'd2) begin
      entries_r[wr_ptr_p1] <= push.slot1;
    end
  end

  assign head        = entries_r[rd_ptr_r];
  assign not_empty   = (count_r != '0);
  // Fewer than two free entries: a new row could not be stored.
  assign almost_full = (count_r > QCNT_W'(QDEPTH - 2));

endmodule

// File: sv/life_automaton_row_step.sv
// ----------------------------------------------------------------------------
// life_automaton_row_step: one Conway Life generation, one row per beat
// Streams a grid row by row and returns the next generation, one row behind.
// ----------------------------------------------------------------------------
// Rows are accepted at one per clock while in_stall is low: all 64 columns
// of a next row are computed side by side by the lane array in the cycle the
// row arrives, and the results go into a four-entry queue. Each row yields
// one result beat, except that the first row of a frame yields none of its
// own; the bottom row adds the zero bottom row carrying frame_end and
// grid_changed, so a frame of one row yields that single beat. The output
// side drains one beat per clock while out_stall is low, so the sustained
// rate is one row per clock; in_stall rises while three or more beats wait
// in the queue. Result beats are registered in the queue before they reach
// the output. Writes to the grid width take effect on the next row.
// ----------------------------------------------------------------------------
module life_automaton_row_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [lrs_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lrs_pkg::MAX_WIDTH-1:0] in_row_cells,
  input  logic                          in_row_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lrs_pkg::MAX_WIDTH-1:0] out_next_row,
  output logic                          out_frame_end,
  output logic                          out_grid_changed
);

  localparam int W     = lrs_pkg::MAX_WIDTH;
  localparam int CFG_W = lrs_pkg::CFG_W;

  logic [CFG_W-1:0]   grid_width_r;
  logic [W-1:0]       upper_row_r, upper_row_nxt;
  logic [W-1:0]       middle_row_r, middle_row_nxt;
  logic [1:0]         rows_seen_r, rows_seen_nxt;
  logic               change_seen_r, change_seen_nxt;

  logic [CFG_W-1:0]   width;
  logic [W-1:0]       mask, inner;
  logic [W-1:0]       up_m, mid_m, cur_m;
  logic [W-1:0]       core_next;
  logic               core_changed;
  logic               change_row;
  logic               change_all;
  logic               accept;
  logic               pop;
  logic               q_not_empty, q_almost_full;
  lrs_pkg::lrs_push_t push;
  lrs_pkg::lrs_res_t  row_res, end_res, head;

  // Grid width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= CFG_W'(lrs_pkg::MAX_WIDTH);
    end else if (cfg_wr_en) begin
      grid_width_r <= cfg_wr_data;
    end
  end

  // Column masks for the width in force; stored rows are masked at use.
  assign width = lrs_pkg::eff_width(grid_width_r);
  assign mask  = lrs_pkg::width_mask(width);
  assign inner = lrs_pkg::interior_mask(width);
  assign up_m  = upper_row_r & mask;
  assign mid_m = middle_row_r & mask;
  assign cur_m = in_row_cells & mask;

  lrs_core u_core (
    .up_row   (up_m),
    .mid_row  (mid_m),
    .down_row (cur_m),
    .inner    (inner),
    .next_row (core_next),
    .changed  (core_changed)
  );

  assign accept = in_valid && !in_stall;

  // Results of the current row and the change flag they carry.
  always_comb begin
    case (rows_seen_r)
      2'd0:    change_row = 1'b0;
      2'd1:    change_row = (mid_m != '0);
      default: change_row = core_changed;
    endcase
    change_all = change_seen_r || change_row || (in_row_last && (cur_m != '0));

    row_res.next_row     = (rows_seen_r == 2'd1) ? '0 : core_next;
    row_res.frame_end    = 1'b0;
    row_res.grid_changed = 1'b0;

    end_res.next_row     = '0;
    end_res.frame_end    = 1'b1;
    end_res.grid_changed = change_all;

    if (rows_seen_r == 2'd0) begin
      push.count = accept && in_row_last ? 2'd1 : 2'd0;
      push.slot0 = end_res;
      push.slot1 = end_res;
    end else begin
      push.count = !accept ? 2'd0 : (in_row_last ? 2'd2 : 2'd1);
      push.slot0 = row_res;
      push.slot1 = end_res;
    end
  end

  // Row buffers and frame state.
  always_comb begin
    upper_row_nxt   = upper_row_r;
    middle_row_nxt  = middle_row_r;
    rows_seen_nxt   = rows_seen_r;
    change_seen_nxt = change_seen_r;
    if (accept) begin
      if (in_row_last) begin
        upper_row_nxt   = '0;
        middle_row_nxt  = '0;
        rows_seen_nxt   = 2'd0;
        change_seen_nxt = 1'b0;
      end else begin
        upper_row_nxt   = middle_row_r;
        middle_row_nxt  = in_row_cells;
        rows_seen_nxt   = (rows_seen_r == 2'd2) ? 2'd2 : rows_seen_r + 2'd1;
        change_seen_nxt = change_seen_r || change_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_row_r   <= '0;
      middle_row_r  <= '0;
      rows_seen_r   <= 2'd0;
      change_seen_r <= 1'b0;
    end else begin
      upper_row_r   <= upper_row_nxt;
      middle_row_r  <= middle_row_nxt;
      rows_seen_r   <= rows_seen_nxt;
      change_seen_r <= change_seen_nxt;
    end
  end

  // Result queue and output beat.
  assign pop = q_not_empty && !out_stall;

  lrs_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .pop         (pop),
    .not_empty   (q_not_empty),
    .almost_full (q_almost_full),
    .head        (head)
  );

  assign in_stall         = q_almost_full;
  assign out_valid        = q_not_empty;
  assign out_next_row     = head.next_row;
  assign out_frame_end    = head.frame_end;
  assign out_grid_changed = head.grid_changed;

endmodule
